// ----- sv/json_string_unescape_core_assert.svh -----
// Assertion macros shared by the JSON string unescape modules.
`ifndef JSON_STRING_UNESCAPE_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked during reset.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and masked during reset.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/jsu_pkg.sv -----
// Types and constants shared by the JSON string unescape modules.
package jsu_pkg;

    localparam int MAX_BYTES = 4;

    localparam logic [1:0] STATUS_BUSY   = 2'd0;
    localparam logic [1:0] STATUS_CLOSED = 2'd1;
    localparam logic [1:0] STATUS_ERROR  = 2'd2;

    // All output produced by one source byte: up to four UTF-8 bytes and a status.
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic [1:0]                status;
    } result_t;

endpackage

// ----- sv/jsu_decode.sv -----
// Token scanner: escape state, hex accumulation and UTF-8 encoding of one byte.
`include "json_string_unescape_core_assert.svh"
module jsu_decode
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        in_byte,
    input  logic              source_end,
    output jsu_pkg::result_t  result
);

    localparam logic [2:0] MODE_WAIT     = 3'd0;
    localparam logic [2:0] MODE_STR      = 3'd1;
    localparam logic [2:0] MODE_ESC      = 3'd2;
    localparam logic [2:0] MODE_HEX1     = 3'd3;
    localparam logic [2:0] MODE_HIGH     = 3'd4;
    localparam logic [2:0] MODE_HIGH_BSL = 3'd5;
    localparam logic [2:0] MODE_HEX2     = 3'd6;

    localparam logic [7:0] CHR_QUOTE = 8'h22;
    localparam logic [7:0] CHR_BSL   = 8'h5C;
    localparam logic [7:0] CHR_U     = 8'h75;

    localparam logic [15:0] HIGH_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_LAST  = 16'hDBFF;
    // 0x10000 - 0xDC00: offset of a surrogate pair once the low half is added whole.
    localparam logic [20:0] PAIR_OFFSET = 21'h02400;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      count;
    } enc_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
            h.value = 4'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h66)
            h.value = 4'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46)
            h.value = 4'(c - 8'h37);
        else
            h.ok = 1'b0;
        return h;
    endfunction

    function automatic logic [7:0] escape_byte(input logic [7:0] c);
        logic [7:0] b;
        case (c)
            8'h6E:   b = 8'h0A;
            8'h74:   b = 8'h09;
            8'h72:   b = 8'h0D;
            8'h62:   b = 8'h08;
            8'h66:   b = 8'h0C;
            default: b = c;
        endcase
        return b;
    endfunction

    function automatic enc_t encode(input logic [20:0] cp);
        enc_t e;
        e.bytes = '0;
        e.count = 3'd0;
        if (cp <= 21'h7F) begin
            e.bytes[0] = cp[7:0];
            e.count    = 3'd1;
        end
        else if (cp <= 21'h7FF) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.count    = 3'd2;
        end
        else if (cp <= 21'hFFFF) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.count    = 3'd3;
        end
        else if (cp <= 21'h10FFFF) begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.count    = 3'd4;
        end
        return e;
    endfunction

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  hex_count_reg, hex_count_next;
    logic [15:0] code_accum_reg, code_accum_next;
    logic [15:0] high_half_reg, high_half_next;

    hex_t        hex;
    logic [15:0] accum_shift;
    logic        enc_en;
    logic [20:0] enc_cp;
    logic        tail_en;
    logic [7:0]  tail_byte;
    logic [1:0]  status;
    enc_t        enc;

    assign hex         = hex_digit(in_byte);
    assign accum_shift = {code_accum_reg[11:0], hex.value};

    always_comb
    begin
        mode_next       = mode_reg;
        hex_count_next  = hex_count_reg;
        code_accum_next = code_accum_reg;
        high_half_next  = high_half_reg;
        enc_en          = 1'b0;
        enc_cp          = {5'd0, high_half_reg};
        tail_en         = 1'b0;
        tail_byte       = in_byte;
        status          = jsu_pkg::STATUS_BUSY;

        unique case (mode_reg)
            MODE_STR:
            begin
                if (in_byte == CHR_QUOTE)
                    status = jsu_pkg::STATUS_CLOSED;
                else if (in_byte == CHR_BSL)
                    mode_next = MODE_ESC;
                else
                    tail_en = 1'b1;
            end
            MODE_ESC:
            begin
                mode_next = MODE_STR;
                if (in_byte == CHR_U)
                begin
                    mode_next       = MODE_HEX1;
                    hex_count_next  = 2'd0;
                    code_accum_next = 16'd0;
                end
                else
                begin
                    tail_en   = 1'b1;
                    tail_byte = escape_byte(in_byte);
                end
            end
            MODE_HEX1, MODE_HEX2:
            begin
                if (!hex.ok)
                    status = jsu_pkg::STATUS_ERROR;
                else
                begin
                    code_accum_next = accum_shift;
                    if (hex_count_reg == 2'd3)
                    begin
                        hex_count_next = 2'd0;
                        mode_next      = MODE_STR;
                        if (mode_reg == MODE_HEX2)
                        begin
                            enc_en = 1'b1;
                            enc_cp = PAIR_OFFSET + {1'b0, high_half_reg[9:0], 10'd0}
                                     + {5'd0, accum_shift};
                        end
                        else if (accum_shift >= HIGH_FIRST && accum_shift <= HIGH_LAST)
                        begin
                            high_half_next = accum_shift;
                            mode_next      = MODE_HIGH;
                        end
                        else
                        begin
                            enc_en = 1'b1;
                            enc_cp = {5'd0, accum_shift};
                        end
                    end
                    else
                        hex_count_next = hex_count_reg + 2'd1;
                end
            end
            MODE_HIGH:
            begin
                if (in_byte == CHR_BSL)
                    mode_next = MODE_HIGH_BSL;
                else
                begin
                    // The pending high half goes out alone, then the byte is ordinary text.
                    enc_en    = 1'b1;
                    mode_next = MODE_STR;
                    if (in_byte == CHR_QUOTE)
                        status = jsu_pkg::STATUS_CLOSED;
                    else
                        tail_en = 1'b1;
                end
            end
            MODE_HIGH_BSL:
            begin
                if (in_byte == CHR_U)
                begin
                    mode_next       = MODE_HEX2;
                    hex_count_next  = 2'd0;
                    code_accum_next = 16'd0;
                end
                else
                begin
                    enc_en    = 1'b1;
                    mode_next = MODE_STR;
                    tail_en   = 1'b1;
                    tail_byte = escape_byte(in_byte);
                end
            end
            default:
            begin
                if (in_byte == CHR_QUOTE)
                    mode_next = MODE_STR;
                else
                    status = jsu_pkg::STATUS_ERROR;
            end
        endcase

        // Source ended inside the token: flush a pending high half or backslash, then report the error.
        if (source_end && status == jsu_pkg::STATUS_BUSY)
        begin
            if (mode_next == MODE_HIGH)
            begin
                enc_en = 1'b1;
                enc_cp = {5'd0, high_half_next};
            end
            else if (mode_next == MODE_HIGH_BSL)
            begin
                enc_en    = 1'b1;
                enc_cp    = {5'd0, high_half_next};
                tail_en   = 1'b1;
                tail_byte = CHR_BSL;
            end
            else if (mode_next == MODE_ESC)
            begin
                tail_en   = 1'b1;
                tail_byte = CHR_BSL;
            end
            status = jsu_pkg::STATUS_ERROR;
        end

        if (status != jsu_pkg::STATUS_BUSY)
        begin
            mode_next       = MODE_WAIT;
            hex_count_next  = 2'd0;
            code_accum_next = 16'd0;
            high_half_next  = 16'd0;
        end
    end

    always_comb
    begin
        enc = enc_en ? encode(enc_cp) : '0;
        result.bytes  = enc.bytes;
        result.count  = enc.count;
        result.status = status;
        // An encoded sequence that is followed by a byte is never longer than three.
        if (tail_en)
        begin
            result.bytes[enc.count[1:0]] = tail_byte;
            result.count                 = enc.count + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_WAIT;
            hex_count_reg  <= 2'd0;
            code_accum_reg <= 16'd0;
            high_half_reg  <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg       <= mode_next;
            hex_count_reg  <= hex_count_next;
            code_accum_reg <= code_accum_next;
            high_half_reg  <= high_half_next;
        end
    end

    `JSU_ASSERT_NOW(a_pair_needs_high_half,
        mode_reg == MODE_HEX2 || mode_reg == MODE_HIGH || mode_reg == MODE_HIGH_BSL,
        high_half_reg[15:10] == 6'b110110,
        "second escape of a pair without a stored high surrogate")
    `JSU_ASSERT_NOW(a_count_only_in_hex,
        hex_count_reg != 2'd0,
        mode_reg == MODE_HEX1 || mode_reg == MODE_HEX2,
        "hex digit count left over outside a unicode escape")
    `JSU_ASSERT_NEXT(a_end_of_token_clears,
        accept && result.status != jsu_pkg::STATUS_BUSY,
        mode_reg == MODE_WAIT && high_half_reg == 16'd0 && code_accum_reg == 16'd0,
        "scanner state not cleared after a closed or failed token")

endmodule

// ----- sv/jsu_emit.sv -----
// Result register and byte serialiser for the decoded output stream.
`include "json_string_unescape_core_assert.svh"
module jsu_emit
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  jsu_pkg::result_t  result,
    output logic              load_ready,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,
    output logic              m_axis_tlast,
    output logic [2:0]        m_axis_tuser
);

    jsu_pkg::result_t result_reg;
    logic             valid_reg;
    logic [1:0]       index_reg;
    logic [1:0]       last_index;
    logic             out_fire;
    logic             run_done;
    logic [1:0]       run_status;

    // A step with no decoded byte still yields one transfer, flagged as empty.
    assign last_index = (result_reg.count == 3'd0) ? 2'd0 : 2'(result_reg.count - 3'd1);
    assign out_fire   = m_axis_tvalid && m_axis_tready;
    assign run_done   = out_fire && m_axis_tlast;
    assign load_ready = !valid_reg || run_done;

    assign run_status    = m_axis_tlast ? result_reg.status : jsu_pkg::STATUS_BUSY;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = result_reg.bytes[index_reg];
    assign m_axis_tlast  = (index_reg == last_index);
    assign m_axis_tuser  = {run_status, (result_reg.count != 3'd0)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            index_reg <= 2'd0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            index_reg <= 2'd0;
        end
        else if (run_done)
            valid_reg <= 1'b0;
        else if (out_fire)
            index_reg <= index_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    `JSU_ASSERT_NOW(a_index_in_run,
        valid_reg,
        index_reg <= last_index,
        "output index ran past the last byte of the run")
    `JSU_ASSERT_NOW(a_empty_run_single,
        valid_reg && result_reg.count == 3'd0,
        index_reg == 2'd0 && m_axis_tlast && m_axis_tdata == 8'd0,
        "empty result must be a single zero transfer")
    `JSU_ASSERT_NEXT(a_run_advances,
        out_fire && !m_axis_tlast,
        valid_reg && index_reg == $past(index_reg) + 2'd1,
        "run did not advance to its next byte")

endmodule

// ----- sv/json_string_unescape_core.sv -----
// JSON string unescape core: raw source bytes in, decoded UTF-8 bytes out.
// Each accepted source byte is decoded in the cycle it is taken and its whole output (up to
// four UTF-8 bytes and a token status) lands in one result register, which then drains one
// byte per transfer. A source byte that yields zero or one byte therefore lets the input
// accept a byte every cycle while the output is not stalled; a byte that yields n > 1 bytes
// holds the result register, and so the input, until all n bytes have gone out (at most four,
// for a surrogate pair or a flushed high surrogate). Output stalls feed straight back to
// s_axis_tready. Every source byte gives at least one output transfer; tlast marks the last
// transfer of a byte, and only there does the status field carry closed or error. On error,
// bytes already sent for the broken token are to be discarded.
module json_string_unescape_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // source_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,   // run_last
    output logic [2:0]  m_axis_tuser    // [0] byte_valid, [2:1] token_status
);

    jsu_pkg::result_t result;
    logic             accept;

    assign accept = s_axis_tvalid && s_axis_tready;

    jsu_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .in_byte    (s_axis_tdata),
        .source_end (s_axis_tlast),
        .result     (result)
    );

    jsu_emit u_emit
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .result        (result),
        .load_ready    (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- tb/json_string_unescape_core_tb.sv -----
// Self-checking testbench for the JSON string unescape core.
`timescale 1ns / 100ps

module json_string_unescape_core_tb;

    localparam logic [7:0] QUOTE  = 8'h22;
    localparam logic [7:0] BSLASH = 8'h5C;
    localparam logic [7:0] LTR_U  = 8'h75;
    localparam int         RANDOM_BYTES = 350;

    typedef enum logic [2:0] {
        SCAN_WAIT,
        SCAN_STR,
        SCAN_ESC,
        SCAN_HEX,
        SCAN_HIGH,
        SCAN_HIGH_BSL,
        SCAN_HEX_LOW
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic [1:0] status;
    } decoded_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       at_end;
    } source_byte_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [2:0] m_axis_tuser;

    source_byte_t source_q[$];
    logic [7:0]   token_q[$];

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - 8'h30);
        if (c >= "a" && c <= "f")
            return int'(c - 8'h61) + 10;
        if (c >= "A" && c <= "F")
            return int'(c - 8'h41) + 10;
        return -1;
    endfunction

    // Predicts the decoded byte stream and checks the output transfers against it.
    class unescape_scoreboard;
        scan_mode_t    mode;
        logic [1:0]    hex_cnt;
        logic [15:0]   accum;
        logic [15:0]   high_half;
        logic [1:0]    status;
        logic [7:0]    emitted[$];
        decoded_byte_t expected_q[$];
        int            errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            mode      = SCAN_WAIT;
            hex_cnt   = 2'd0;
            accum     = 16'd0;
            high_half = 16'd0;
        endfunction

        function void put(logic [7:0] b);
            if (emitted.size() < jsu_pkg::MAX_BYTES)
                emitted = {emitted, b};
        endfunction

        function void put_code_point(logic [31:0] cp);
            if (cp <= 32'h7F) begin
                put(cp[7:0]);
            end
            else if (cp <= 32'h7FF) begin
                put(8'hC0 | 8'(cp >> 6));
                put({2'b10, cp[5:0]});
            end
            else if (cp <= 32'hFFFF) begin
                put(8'hE0 | 8'(cp >> 12));
                put({2'b10, cp[11:6]});
                put({2'b10, cp[5:0]});
            end
            else if (cp <= 32'h10FFFF) begin
                put(8'hF0 | 8'(cp >> 18));
                put({2'b10, cp[17:12]});
                put({2'b10, cp[11:6]});
                put({2'b10, cp[5:0]});
            end
        endfunction

        function void in_string(logic [7:0] c);
            if (c == QUOTE)
                status = jsu_pkg::STATUS_CLOSED;
            else if (c == BSLASH)
                mode = SCAN_ESC;
            else
                put(c);
        endfunction

        function void escaped(logic [7:0] c);
            mode = SCAN_STR;
            case (c)
                "n":     put(8'h0A);
                "t":     put(8'h09);
                "r":     put(8'h0D);
                "b":     put(8'h08);
                "f":     put(8'h0C);
                LTR_U:
                begin
                    mode    = SCAN_HEX;
                    hex_cnt = 2'd0;
                    accum   = 16'd0;
                end
                default: put(c);
            endcase
        endfunction

        // Returns 1 once the fourth digit of an escape has been taken.
        function bit take_hex(logic [7:0] c);
            int v;
            v = hex_value(c);
            if (v < 0) begin
                status = jsu_pkg::STATUS_ERROR;
                return 1'b0;
            end
            accum = {accum[11:0], v[3:0]};
            if (hex_cnt == 2'd3)
                return 1'b1;
            hex_cnt++;
            return 1'b0;
        endfunction

        function void note_source_byte(logic [7:0] c, logic at_end);
            logic [31:0]   cp;
            int            count;
            decoded_byte_t item;
            emitted.delete();
            status = jsu_pkg::STATUS_BUSY;
            case (mode)
                SCAN_STR: in_string(c);
                SCAN_ESC: escaped(c);
                SCAN_HEX:
                begin
                    if (take_hex(c)) begin
                        hex_cnt = 2'd0;
                        if (accum >= 16'hD800 && accum <= 16'hDBFF) begin
                            high_half = accum;
                            mode      = SCAN_HIGH;
                        end
                        else begin
                            put_code_point({16'd0, accum});
                            mode = SCAN_STR;
                        end
                    end
                end
                SCAN_HIGH:
                begin
                    if (c == BSLASH) begin
                        mode = SCAN_HIGH_BSL;
                    end
                    else begin
                        put_code_point({16'd0, high_half});
                        mode = SCAN_STR;
                        in_string(c);
                    end
                end
                SCAN_HIGH_BSL:
                begin
                    if (c == LTR_U) begin
                        mode    = SCAN_HEX_LOW;
                        hex_cnt = 2'd0;
                        accum   = 16'd0;
                    end
                    else begin
                        put_code_point({16'd0, high_half});
                        escaped(c);
                    end
                end
                SCAN_HEX_LOW:
                begin
                    if (take_hex(c)) begin
                        // The pair is combined with plain 32-bit wrap-around.
                        cp = ({16'd0, high_half} - 32'hD800) << 10;
                        cp = cp + 32'h10000 + ({16'd0, accum} - 32'hDC00);
                        hex_cnt = 2'd0;
                        put_code_point(cp);
                        mode = SCAN_STR;
                    end
                end
                default:
                begin
                    if (c == QUOTE)
                        mode = SCAN_STR;
                    else
                        status = jsu_pkg::STATUS_ERROR;
                end
            endcase

            // Source ends inside a token: flush a pending high half or backslash, then report an error.
            if (at_end && status == jsu_pkg::STATUS_BUSY) begin
                if (mode == SCAN_HIGH) begin
                    put_code_point({16'd0, high_half});
                end
                else if (mode == SCAN_HIGH_BSL) begin
                    put_code_point({16'd0, high_half});
                    put(BSLASH);
                end
                else if (mode == SCAN_ESC) begin
                    put(BSLASH);
                end
                status = jsu_pkg::STATUS_ERROR;
            end

            if (status != jsu_pkg::STATUS_BUSY)
                clear_scan();

            count = (emitted.size() > 0) ? emitted.size() : 1;
            for (int k = 0; k < count; k++) begin
                item.valid  = (k < emitted.size());
                item.data   = item.valid ? emitted[k] : 8'h00;
                item.last   = (k == count - 1);
                item.status = item.last ? status : jsu_pkg::STATUS_BUSY;
                expected_q  = {expected_q, item};
            end
        endfunction

        function void check_output(logic [7:0] data, logic valid, logic last,
                                   logic [1:0] st);
            decoded_byte_t exp_item;
            if (expected_q.size() == 0) begin
                $error("unexpected output transfer: out_byte %h", data);
                errors++;
                return;
            end
            exp_item = expected_q.pop_front();
            if (data !== exp_item.data) begin
                $error("out_byte: expected %h, got %h", exp_item.data, data);
                errors++;
            end
            if (valid !== exp_item.valid) begin
                $error("byte_valid: expected %b, got %b", exp_item.valid, valid);
                errors++;
            end
            if (last !== exp_item.last) begin
                $error("run_last: expected %b, got %b", exp_item.last, last);
                errors++;
            end
            if (st !== exp_item.status) begin
                $error("token_status: expected %0d, got %0d", exp_item.status, st);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    unescape_scoreboard sb;

    json_string_unescape_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void push_src(logic [7:0] b, logic at_end);
        source_byte_t s;
        s.data   = b;
        s.at_end = at_end;
        source_q = {source_q, s};
    endfunction

    function automatic void add_token(logic [7:0] b);
        token_q = {token_q, b};
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + {4'h0, n};
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, n} - 8'd10;
    endfunction

    function automatic void push_hex16(logic [15:0] v);
        for (int i = 3; i >= 0; i--)
            add_token(hex_char(v[i*4 +: 4]));
    endfunction

    function automatic logic [15:0] high_surrogate();
        return 16'hD800 + 16'($urandom_range(0, 16'h3FF));
    endfunction

    function automatic void push_piece();
        int         kind;
        int         n;
        logic [7:0] b;
        logic [15:0] v;
        kind = $urandom_range(0, 99);
        if (kind < 25) begin
            do b = 8'($urandom_range(0, 255)); while (b == QUOTE || b == BSLASH);
            add_token(b);
        end
        else if (kind < 40) begin
            add_token(BSLASH);
            case ($urandom_range(0, 7))
                0:       add_token(QUOTE);
                1:       add_token(BSLASH);
                2:       add_token("/");
                3:       add_token("n");
                4:       add_token("b");
                5:       add_token("t");
                6:       add_token("r");
                default: add_token("f");
            endcase
        end
        else if (kind < 48) begin
            // Any other escaped byte stands for itself.
            do b = 8'($urandom_range(0, 255)); while (b == LTR_U);
            add_token(BSLASH);
            add_token(b);
        end
        else if (kind < 63) begin
            case ($urandom_range(0, 4))
                0:       v = 16'($urandom_range(0, 16'h7F));
                1:       v = 16'($urandom_range(16'h80, 16'h7FF));
                2:       v = 16'($urandom_range(16'h800, 16'hFFFF));
                3:       v = 16'($urandom_range(16'hDC00, 16'hDFFF));
                default: v = 16'($urandom_range(0, 16'hFFFF));
            endcase
            add_token(BSLASH);
            add_token(LTR_U);
            push_hex16(v);
        end
        else if (kind < 80) begin
            // Surrogate pair; a stray second half drives the wrap-around and overflow cases.
            add_token(BSLASH);
            add_token(LTR_U);
            push_hex16(high_surrogate());
            add_token(BSLASH);
            add_token(LTR_U);
            if ($urandom_range(0, 3) != 0)
                push_hex16(16'($urandom_range(16'hDC00, 16'hDFFF)));
            else
                push_hex16(16'($urandom_range(0, 16'hFFFF)));
        end
        else if (kind < 90) begin
            add_token(BSLASH);
            add_token(LTR_U);
            push_hex16(high_surrogate());
            if ($urandom_range(0, 1)) begin
                do b = 8'($urandom_range(0, 255)); while (b == LTR_U);
                add_token(BSLASH);
                add_token(b);
            end
        end
        else begin
            // Broken hex escape, either on its own or as the second half of a pair.
            if ($urandom_range(0, 1)) begin
                add_token(BSLASH);
                add_token(LTR_U);
                push_hex16(high_surrogate());
            end
            add_token(BSLASH);
            add_token(LTR_U);
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                add_token(hex_char(4'($urandom_range(0, 15))));
            do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0);
            add_token(b);
        end
    endfunction

    function automatic void push_random_token();
        int cut;
        int r;
        bit ends;
        token_q.delete();
        if ($urandom_range(0, 99) < 12) begin
            // Stray bytes between tokens.
            r = $urandom_range(1, 3);
            for (int i = 0; i < r; i++)
                push_src(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
        end
        else begin
            add_token(QUOTE);
            r = $urandom_range(0, 5);
            for (int i = 0; i < r; i++)
                push_piece();
            add_token(QUOTE);
            cut  = token_q.size();
            ends = 1'b0;
            r    = $urandom_range(0, 99);
            if (r < 12) begin
                cut  = $urandom_range(1, token_q.size());
                ends = 1'b1;
            end
            else if (r < 16) begin
                ends = 1'b1;
            end
            for (int i = 0; i < cut; i++)
                push_src(token_q[i], ends && (i == cut - 1));
        end
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic send_source_byte(source_byte_t s, bit burst);
        int gap;
        gap = draw_wait(burst);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s.data;
        s_axis_tlast  <= s.at_end;
        do @(negedge clk); while (!s_axis_tready);
        sb.note_source_byte(s.data, s.at_end);
        @(posedge clk);
    endtask

    task automatic take_results();
        int stall;
        bit burst;
        burst = 1'b0;
        forever begin
            if ($urandom_range(0, 29) == 0)
                burst = !burst;
            stall = draw_wait(burst);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            do @(negedge clk); while (!m_axis_tvalid || !m_axis_tready);
            sb.check_output(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[2:1]);
            @(posedge clk);
        end
    endtask

    initial
    begin
        int directed_cnt;
        bit burst;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        sb = new();

        // Missing opening quote, then a source that ends on the opening quote.
        push_src(8'h00, 1'b0);
        push_src(QUOTE, 1'b1);
        // Top byte value, a simple escape and a surrogate pair giving four bytes.
        push_src(QUOTE, 1'b0);
        push_src(8'hFF, 1'b0);
        push_src(BSLASH, 1'b0);
        push_src("t", 1'b0);
        push_src(BSLASH, 1'b0);
        push_src(LTR_U, 1'b0);
        push_src("d", 1'b0);
        push_src("8", 1'b0);
        push_src("0", 1'b0);
        push_src("0", 1'b0);
        push_src(BSLASH, 1'b0);
        push_src(LTR_U, 1'b0);
        push_src("D", 1'b0);
        push_src("C", 1'b0);
        push_src("0", 1'b0);
        push_src("0", 1'b0);
        push_src(QUOTE, 1'b0);
        // Source ends right after a backslash.
        push_src(QUOTE, 1'b0);
        push_src(BSLASH, 1'b1);
        // Bad hex digit inside a unicode escape.
        push_src(QUOTE, 1'b0);
        push_src(BSLASH, 1'b0);
        push_src(LTR_U, 1'b0);
        push_src("0", 1'b0);
        push_src("0", 1'b0);
        push_src("g", 1'b0);
        directed_cnt = source_q.size();
        while (source_q.size() < directed_cnt + RANDOM_BYTES)
            push_random_token();

        repeat (6) @(posedge clk);
        rst_n         <= 1'b1;
        m_axis_tready <= 1'b1;
        @(posedge clk);

        fork
            take_results();
        join_none

        burst = 1'b0;
        foreach (source_q[i]) begin
            if ($urandom_range(0, 29) == 0)
                burst = !burst;
            send_source_byte(source_q[i], burst);
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() > 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/jsu_emit.sv
sv/json_string_unescape_core.sv
tb/json_string_unescape_core_tb.sv
